[src/bfd_pkg.sv]
package bfd_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int CNT_W = 7;
	localparam int DATA_W = 8;
	localparam int STAT_W = 32;
	localparam logic [CNT_W-1:0] DEFAULT_CAPACITY = 7'd16;

	localparam logic [2:0] MODE_WRITE  = 3'd0;
	localparam logic [2:0] MODE_ATOMIC = 3'd1;
	localparam logic [2:0] MODE_READ   = 3'd2;
	localparam logic [2:0] MODE_PEEK   = 3'd3;
	localparam logic [2:0] MODE_DROP   = 3'd4;
	localparam logic [2:0] MODE_RESET  = 3'd5;

	// One queued command as it travels from the front to the back.
	typedef struct packed {
		logic [2:0]        mode;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  length;
		logic              run_first;
		logic              run_last;
		logic              read_like;
	} cmd_t;

	// Capacity in use: zero selects the default, anything above the depth is clamped.
	function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] depth);
		logic [CNT_W-1:0] c;
		c = v;
		if (c == '0) begin
			c = DEFAULT_CAPACITY;
		end
		if (c > depth) begin
			c = depth;
		end
		return c;
	endfunction

	// Pointer step with wrap by a single conditional subtraction.
	function automatic logic [CNT_W-1:0] advance(input logic [CNT_W-1:0] p,
			input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] s;
		s = {1'b0, p} + {1'b0, n};
		if (s >= {1'b0, cap}) begin
			s = s - {1'b0, cap};
		end
		return s[CNT_W-1:0];
	endfunction

endpackage

[src/bfd_ram.sv]
module bfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/bfd_front.sv]
module bfd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    mode,
	input  logic [7:0]    data_in,
	input  logic [6:0]    length,
	input  logic          run_first,
	input  logic          run_last,
	output logic          cmd_valid,
	output bfd_pkg::cmd_t cmd,
	input  logic          pop
);

	// Two-entry command queue; the back pops from the head.
	bfd_pkg::cmd_t entry_q [2];
	bfd_pkg::cmd_t in_cmd;
	logic          head_q;
	logic          tail_q;
	logic [1:0]    count_q;
	logic          push;
	logic          do_pop;

	always_comb begin
		in_cmd.mode      = mode;
		in_cmd.data      = data_in;
		in_cmd.length    = length;
		in_cmd.run_first = run_first;
		in_cmd.run_last  = run_last;
		in_cmd.read_like = mode inside {bfd_pkg::MODE_READ, bfd_pkg::MODE_PEEK};
	end

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[head_q];
	assign do_pop    = pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[tail_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 1'b0;
			tail_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				tail_q <= !tail_q;
			end
			if (do_pop) begin
				head_q <= !head_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

[src/bfd_back.sv]
module bfd_back #(
	parameter int DEPTH = bfd_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  bfd_pkg::cmd_t cmd,
	output logic          pop,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [6:0]    cfg_cap,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    data_out,
	output logic          data_valid,
	output logic          accepted,
	output logic          too_long,
	output logic          last,
	output logic [6:0]    fill_level,
	output logic [6:0]    peak_fill,
	output logic [31:0]   overflow_events,
	output logic [31:0]   bytes_written,
	output logic [31:0]   bytes_read
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = bfd_pkg::CNT_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] CAP_RESET = bfd_pkg::eff_cap(bfd_pkg::DEFAULT_CAPACITY, DEPTH_C);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic          state_q;
	logic [CW-1:0] cap_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] peak_q;
	logic [31:0]   ovf_q;
	logic [31:0]   wtot_q;
	logic [31:0]   rtot_q;
	logic          refused_q;
	logic          rejected_q;
	logic [CW-1:0] left_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] rem_q;
	logic          peek_q;

	logic          o_valid_q;
	logic [7:0]    o_data_q;
	logic          o_dv_q;
	logic          o_acc_q;
	logic          o_tl_q;
	logic          o_last_q;
	logic [CW-1:0] o_fill_q;
	logic [CW-1:0] o_peak_q;
	logic [31:0]   o_ovf_q;
	logic [31:0]   o_wtot_q;
	logic [31:0]   o_rtot_q;

	logic          out_free;
	logic          cfg_take;
	logic          emit;
	logic [CW-1:0] cnt;
	logic          run_start;
	logic          status_op;

	logic [CW-1:0] n_wp;
	logic [CW-1:0] n_rp;
	logic [CW-1:0] fbase;
	logic [CW-1:0] n_fill;
	logic [CW-1:0] n_peak;
	logic [31:0]   n_ovf;
	logic [31:0]   n_wtot;
	logic [31:0]   n_rtot;
	logic          n_refused;
	logic          n_rejected;
	logic [CW-1:0] n_left;
	logic          n_acc;
	logic          n_tl;
	logic          we;
	logic [CW-1:0] room;
	logic [CW-1:0] cut;

	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic [CW-1:0] nidx;
	logic          run_end;

	assign out_free  = !o_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && cmd_valid && out_free;
	assign cfg_ready = (state_q == ST_IDLE) && !cmd_valid;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign cnt       = (cmd.length < fill_q) ? cmd.length : fill_q;
	assign run_start = pop && cmd.read_like && (cnt != '0);
	assign status_op = pop && !run_start;
	assign emit      = (state_q == ST_RUN) && out_free;
	assign nidx      = bfd_pkg::advance(CW'(idx_q), CW'(1), cap_q);
	assign run_end   = (rem_q == CW'(1));

	// One command that leaves a single status result.
	always_comb begin
		n_rp       = CW'(rp_q);
		fbase      = fill_q;
		n_ovf      = ovf_q;
		n_rtot     = rtot_q;
		n_refused  = refused_q;
		n_rejected = rejected_q;
		n_left     = left_q;
		n_acc      = 1'b0;
		n_tl       = 1'b0;
		we         = 1'b0;
		room       = cap_q - fill_q;
		cut        = '0;
		n_wp       = CW'(wp_q);
		n_fill     = fill_q;
		n_peak     = peak_q;
		n_wtot     = wtot_q;
		case (cmd.mode)
			bfd_pkg::MODE_WRITE: begin
				if (cmd.run_first) begin
					n_refused = 1'b0;
				end
				if (!n_refused) begin
					if (fill_q >= cap_q) begin
						n_ovf     = ovf_q + 32'd1;
						n_refused = 1'b1;
					end else begin
						we = 1'b1;
					end
				end
			end
			bfd_pkg::MODE_ATOMIC: begin
				if (cmd.run_first) begin
					n_rejected = 1'b0;
					n_left     = '0;
					if (cmd.length > cap_q) begin
						n_rejected = 1'b1;
					end else if (cmd.length != '0) begin
						if (room < cmd.length) begin
							cut   = cmd.length - room;
							n_rp  = bfd_pkg::advance(CW'(rp_q), cut, cap_q);
							fbase = fill_q - cut;
							n_ovf = ovf_q + 32'd1;
						end
						n_left = cmd.length;
					end
				end
				n_tl = n_rejected;
				if (!n_rejected && (n_left != '0) && (fbase < cap_q)) begin
					we     = 1'b1;
					n_left = n_left - CW'(1);
				end
			end
			bfd_pkg::MODE_DROP: begin
				if (cmd.length != '0) begin
					n_rp  = bfd_pkg::advance(CW'(rp_q), cnt, cap_q);
					fbase = fill_q - cnt;
					n_ovf = ovf_q + 32'd1;
				end
			end
			bfd_pkg::MODE_RESET: begin
				n_rp       = '0;
				fbase      = '0;
				n_ovf      = '0;
				n_rtot     = '0;
				n_refused  = 1'b0;
				n_rejected = 1'b0;
				n_left     = '0;
				n_wp       = '0;
				n_peak     = '0;
				n_wtot     = '0;
			end
			default: begin
			end
		endcase
		n_fill = fbase;
		if (we) begin
			n_acc  = 1'b1;
			n_wp   = bfd_pkg::advance(CW'(wp_q), CW'(1), cap_q);
			n_fill = fbase + CW'(1);
			n_wtot = wtot_q + 32'd1;
			if (n_fill > peak_q) begin
				n_peak = n_fill;
			end
		end
	end

	// Keep the read address on the current byte unless it is being delivered.
	always_comb begin
		if (state_q == ST_IDLE) begin
			ram_raddr = rp_q;
		end else if (emit) begin
			ram_raddr = nidx[AW-1:0];
		end else begin
			ram_raddr = idx_q;
		end
	end

	bfd_ram #(
		.WIDTH(bfd_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (status_op && we),
		.waddr(wp_q),
		.wdata(cmd.data),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= CAP_RESET;
			wp_q       <= '0;
			rp_q       <= '0;
			fill_q     <= '0;
			peak_q     <= '0;
			ovf_q      <= '0;
			wtot_q     <= '0;
			rtot_q     <= '0;
			refused_q  <= 1'b0;
			rejected_q <= 1'b0;
			left_q     <= '0;
			o_valid_q  <= 1'b0;
		end else begin
			if (out_free) begin
				o_valid_q <= status_op || emit;
			end
			if (cfg_take) begin
				cap_q      <= bfd_pkg::eff_cap(cfg_cap, DEPTH_C);
				wp_q       <= '0;
				rp_q       <= '0;
				fill_q     <= '0;
				peak_q     <= '0;
				ovf_q      <= '0;
				wtot_q     <= '0;
				rtot_q     <= '0;
				refused_q  <= 1'b0;
				rejected_q <= 1'b0;
				left_q     <= '0;
			end else if (status_op) begin
				wp_q       <= n_wp[AW-1:0];
				rp_q       <= n_rp[AW-1:0];
				fill_q     <= n_fill;
				peak_q     <= n_peak;
				ovf_q      <= n_ovf;
				wtot_q     <= n_wtot;
				rtot_q     <= n_rtot;
				refused_q  <= n_refused;
				rejected_q <= n_rejected;
				left_q     <= n_left;
			end else if (run_start) begin
				state_q <= ST_RUN;
			end else if (emit) begin
				if (!peek_q) begin
					rp_q   <= nidx[AW-1:0];
					fill_q <= fill_q - CW'(1);
					rtot_q <= rtot_q + 32'd1;
				end
				if (run_end) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_start) begin
			idx_q  <= rp_q;
			rem_q  <= cnt;
			peek_q <= (cmd.mode == bfd_pkg::MODE_PEEK);
		end else if (emit) begin
			idx_q <= nidx[AW-1:0];
			rem_q <= rem_q - CW'(1);
		end
		if (status_op) begin
			o_data_q <= '0;
			o_dv_q   <= 1'b0;
			o_acc_q  <= n_acc;
			o_tl_q   <= n_tl;
			o_last_q <= 1'b1;
			o_fill_q <= n_fill;
			o_peak_q <= n_peak;
			o_ovf_q  <= n_ovf;
			o_wtot_q <= n_wtot;
			o_rtot_q <= n_rtot;
		end else if (emit) begin
			o_data_q <= ram_rdata;
			o_dv_q   <= 1'b1;
			o_acc_q  <= 1'b0;
			o_tl_q   <= 1'b0;
			o_last_q <= run_end;
			o_fill_q <= peek_q ? fill_q : fill_q - CW'(1);
			o_peak_q <= peak_q;
			o_ovf_q  <= ovf_q;
			o_wtot_q <= wtot_q;
			o_rtot_q <= peek_q ? rtot_q : rtot_q + 32'd1;
		end
	end

	assign out_valid       = o_valid_q;
	assign data_out        = o_data_q;
	assign data_valid      = o_dv_q;
	assign accepted        = o_acc_q;
	assign too_long        = o_tl_q;
	assign last            = o_last_q;
	assign fill_level      = o_fill_q;
	assign peak_fill       = o_peak_q;
	assign overflow_events = o_ovf_q;
	assign bytes_written   = o_wtot_q;
	assign bytes_read      = o_rtot_q;

	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_q)
		else $error("fill level above capacity");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(rp_q) < cap_q) && (CW'(wp_q) < cap_q))
		else $error("pointer outside the capacity in use");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		bfd_pkg::advance(CW'(rp_q), fill_q, cap_q) == CW'(wp_q))
		else $error("write pointer does not sit fill bytes after read pointer");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((rem_q != '0) && (rem_q <= fill_q)))
		else $error("delivery run with no bytes owed");

endmodule

[src/byte_fifo_drop_oldest_stats.sv]
// Byte ring FIFO whose capacity (1 to DEPTH slots, written through the capacity port;
// 0 selects 16 and larger values are clamped to DEPTH) is set at run time, with
// overflow statistics. Each input beat carries one command: a plain or atomic write
// stores at most one byte and returns one status result; read and peek return one result
// beat per delivered byte, the final one flagged by last, or a single status beat
// when nothing is held or nothing is asked for; drop and reset return one status
// beat. Every result carries the fill level after it, the peak fill and three
// wrapping 32-bit totals. Writing capacity empties the FIFO and clears all
// statistics; do so only when no command is outstanding. In the back end, a read or
// peek first starts the run and fetches the first byte from the store, then
// delivers one byte per cycle while the output is not stalled, paced by the
// single read port of the byte store and by the one output register; a
// two-beat command queue lets the input side keep accepting while a delivery
// run is in progress.
module byte_fifo_drop_oldest_stats #(
	parameter int DEPTH = bfd_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,

	// Command channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [7:0]  data_in,
	input  logic [6:0]  length,
	input  logic        run_first,
	input  logic        run_last,

	// Capacity register write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  capacity,

	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_out,
	output logic        data_valid,
	output logic        accepted,
	output logic        too_long,
	output logic        last,
	output logic [6:0]  fill_level,
	output logic [6:0]  peak_fill,
	output logic [31:0] overflow_events,
	output logic [31:0] bytes_written,
	output logic [31:0] bytes_read
);

	// The front end classifies each command and holds it in a short queue, so the
	// input side stalls only when that queue is full.
	logic          cmd_valid;
	bfd_pkg::cmd_t cmd;
	logic          pop;

	bfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.data_in  (data_in),
		.length   (length),
		.run_first(run_first),
		.run_last (run_last),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.pop      (pop)
	);

	// The back end owns the byte store, pointers and statistics, and drives the
	// output register; it stalls on its own when the consumer holds off.
	bfd_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.pop            (pop),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_cap        (capacity),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_out       (data_out),
		.data_valid     (data_valid),
		.accepted       (accepted),
		.too_long       (too_long),
		.last           (last),
		.fill_level     (fill_level),
		.peak_fill      (peak_fill),
		.overflow_events(overflow_events),
		.bytes_written  (bytes_written),
		.bytes_read     (bytes_read)
	);

endmodule
